// ===== rtl/rnd_pkg.sv =====
// Package for the RSSI noise detector: widths, codes, reset values and the
// measurement snapshot that travels from the front end to the back end.
// No dependencies.
package rnd_pkg;

	// Width of the sample counters; sums grow by the eight bits of a sample.
	localparam int COUNT_WIDTH = 16;
	localparam int SUM_W       = COUNT_WIDTH + 8;

	// Divider retires two quotient bits per cycle over a padded dividend.
	localparam int DIV_STEPS = (SUM_W + 1) / 2;
	localparam int DVD_W     = 2 * DIV_STEPS;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	// Quotient magnitude never exceeds 128.
	localparam int QUO_W     = 9;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [SUM_W-1:0]       sum_t;

	localparam count_t COUNT_MAX = '1;

	// Input operation codes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam int   CFG_IDX_W           = 1;
	localparam int   CFG_DATA_W          = 16;
	localparam logic CFG_NOISE_THRESHOLD = 1'b0;
	localparam logic CFG_MIN_HIGH_COUNT  = 1'b1;

	localparam logic signed [7:0] THRESHOLD_RESET = -8'sd80;
	localparam logic [15:0]       MIN_HIGH_RESET  = 16'd1;
	localparam logic signed [7:0] EMPTY_MEAN      = -8'sd127;

	// State of one measurement right after a request was applied.
	typedef struct packed {
		sum_t   sum_all;
		sum_t   sum_high;
		count_t cnt_all;
		count_t cnt_high;
		logic   high_noise;
	} snap_t;

endpackage

// ===== rtl/rnd_front.sv =====
// Front end of the RSSI noise detector: configuration registers, request
// intake and the running sums and counts. Depends on rnd_pkg.
module rnd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rnd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rnd_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic                           op,
	input  logic signed [7:0]              rssi_sample,
	input  logic                           fifo_full,
	output logic                           push,
	output rnd_pkg::snap_t                 push_data
);

	logic signed [7:0] thr_q;
	logic [15:0]       min_high_q;
	rnd_pkg::sum_t     sum_all_q, sum_high_q;
	rnd_pkg::count_t   cnt_all_q, cnt_high_q;
	rnd_pkg::sum_t     sum_all_nx, sum_high_nx;
	rnd_pkg::count_t   cnt_all_nx, cnt_high_nx;
	rnd_pkg::sum_t     sample_ext;

	assign sample_ready = !fifo_full;
	assign push         = sample_valid && sample_ready;
	assign sample_ext   = rnd_pkg::SUM_W'(rssi_sample);

	always_comb begin
		sum_all_nx  = sum_all_q;
		sum_high_nx = sum_high_q;
		cnt_all_nx  = cnt_all_q;
		cnt_high_nx = cnt_high_q;
		case (op)
			rnd_pkg::OP_START: begin
				sum_all_nx  = '0;
				sum_high_nx = '0;
				cnt_all_nx  = '0;
				cnt_high_nx = '0;
			end
			rnd_pkg::OP_SAMPLE: begin
				// Drop timed-out reads; freeze a sum once its count saturates.
				if (rssi_sample != 8'sd0) begin
					if (rssi_sample > thr_q && cnt_high_q != rnd_pkg::COUNT_MAX) begin
						sum_high_nx = sum_high_q + sample_ext;
						cnt_high_nx = cnt_high_q + rnd_pkg::COUNT_WIDTH'(1);
					end
					if (cnt_all_q != rnd_pkg::COUNT_MAX) begin
						sum_all_nx = sum_all_q + sample_ext;
						cnt_all_nx = cnt_all_q + rnd_pkg::COUNT_WIDTH'(1);
					end
				end
			end
			default: begin
				sum_all_nx = sum_all_q;
			end
		endcase
	end

	always_comb begin
		push_data.sum_all    = sum_all_nx;
		push_data.sum_high   = sum_high_nx;
		push_data.cnt_all    = cnt_all_nx;
		push_data.cnt_high   = cnt_high_nx;
		push_data.high_noise = 32'(cnt_high_nx) >= 32'(min_high_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= rnd_pkg::THRESHOLD_RESET;
			min_high_q <= rnd_pkg::MIN_HIGH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				rnd_pkg::CFG_NOISE_THRESHOLD: thr_q      <= wr_data[7:0];
				rnd_pkg::CFG_MIN_HIGH_COUNT:  min_high_q <= wr_data;
				default:                      thr_q      <= thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_all_q  <= '0;
			sum_high_q <= '0;
			cnt_all_q  <= '0;
			cnt_high_q <= '0;
		end else if (push) begin
			sum_all_q  <= sum_all_nx;
			sum_high_q <= sum_high_nx;
			cnt_all_q  <= cnt_all_nx;
			cnt_high_q <= cnt_high_nx;
		end
	end

endmodule

// ===== rtl/rnd_fifo.sv =====
// Short snapshot queue between the front end and the back end.
// Depends on rnd_pkg for the snapshot type.
module rnd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rnd_pkg::snap_t push_data,
	input  logic           pop,
	output rnd_pkg::snap_t pop_data,
	output logic           full,
	output logic           empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	rnd_pkg::snap_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/rnd_back.sv =====
// Back end of the RSSI noise detector: a shared radix-4 restoring divider
// that forms both averages, and the result register. Depends on rnd_pkg.
module rnd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fifo_empty,
	input  rnd_pkg::snap_t        fifo_data,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [15:0]           total_samples,
	output logic [15:0]           high_samples,
	output logic signed [7:0]     mean_rssi,
	output logic signed [7:0]     mean_high_rssi,
	output logic                  high_noise
);

	localparam int CW = rnd_pkg::COUNT_WIDTH;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_DIV_ALL  = 4'b0010,
		ST_DIV_HIGH = 4'b0100,
		ST_DONE     = 4'b1000
	} state_t;

	state_t                      state_q;
	rnd_pkg::snap_t              cur_q;
	logic [rnd_pkg::DVD_W-1:0]   dvd_q;
	logic [CW-1:0]               rem_q;
	logic [rnd_pkg::QUO_W-1:0]   quo_q;
	logic [rnd_pkg::STEP_W-1:0]  step_q;
	logic                        neg_q;
	logic [CW-1:0]               div_q;
	logic signed [7:0]           mean_all_q, mean_high_q;

	logic                        load;
	rnd_pkg::sum_t               ld_sum, ld_mag;
	rnd_pkg::count_t             ld_cnt;
	logic [CW:0]                 r1, r2;
	logic                        q1, q2;
	logic [CW-1:0]               rem_nx;
	logic [rnd_pkg::QUO_W-1:0]   quo_nx;
	logic                        last_step;
	logic signed [7:0]           mean_nx;
	rnd_pkg::count_t             cur_cnt;
	logic                        out_free;

	function automatic logic [15:0] cnt_field(rnd_pkg::count_t c);
		logic [31:0] wide;
		wide = 32'(c);
		return wide[15:0];
	endfunction

	assign pop      = (state_q == ST_IDLE) && !fifo_empty;
	assign out_free = !result_valid || result_ready;

	// Operand of the next division: total from the queue head, high from the held entry.
	always_comb begin
		load   = pop || (state_q == ST_DIV_ALL && last_step);
		ld_sum = pop ? fifo_data.sum_all : cur_q.sum_high;
		ld_cnt = pop ? fifo_data.cnt_all : cur_q.cnt_high;
		ld_mag = ld_sum[rnd_pkg::SUM_W-1] ? (~ld_sum + rnd_pkg::SUM_W'(1)) : ld_sum;
	end

	// Two restoring steps per cycle on the magnitude of the sum.
	always_comb begin
		r1 = {rem_q, dvd_q[rnd_pkg::DVD_W-1]};
		q1 = r1 >= {1'b0, div_q};
		if (q1) begin
			r1 = r1 - {1'b0, div_q};
		end
		r2 = {r1[CW-1:0], dvd_q[rnd_pkg::DVD_W-2]};
		q2 = r2 >= {1'b0, div_q};
		if (q2) begin
			r2 = r2 - {1'b0, div_q};
		end
		rem_nx    = r2[CW-1:0];
		quo_nx    = {quo_q[rnd_pkg::QUO_W-3:0], q1, q2};
		last_step = step_q == rnd_pkg::STEP_W'(rnd_pkg::DIV_STEPS - 1);
		cur_cnt   = (state_q == ST_DIV_ALL) ? cur_q.cnt_all : cur_q.cnt_high;
		if (cur_cnt == '0) begin
			mean_nx = rnd_pkg::EMPTY_MEAN;
		end else if (neg_q) begin
			mean_nx = -quo_nx[7:0];
		end else begin
			mean_nx = quo_nx[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= fifo_data;
		end
		if (load) begin
			dvd_q  <= rnd_pkg::DVD_W'(ld_mag);
			rem_q  <= '0;
			quo_q  <= '0;
			step_q <= '0;
			neg_q  <= ld_sum[rnd_pkg::SUM_W-1];
			div_q  <= ld_cnt;
		end else begin
			dvd_q  <= {dvd_q[rnd_pkg::DVD_W-3:0], 2'b00};
			rem_q  <= rem_nx;
			quo_q  <= quo_nx;
			step_q <= step_q + rnd_pkg::STEP_W'(1);
		end
		if (state_q == ST_DIV_ALL && last_step) begin
			mean_all_q <= mean_nx;
		end
		if (state_q == ST_DIV_HIGH && last_step) begin
			mean_high_q <= mean_nx;
		end
		if (state_q == ST_DONE && out_free) begin
			total_samples  <= cnt_field(cur_q.cnt_all);
			high_samples   <= cnt_field(cur_q.cnt_high);
			mean_rssi      <= mean_all_q;
			mean_high_rssi <= mean_high_q;
			high_noise     <= cur_q.high_noise;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV_ALL;
					end
				end
				ST_DIV_ALL: begin
					if (last_step) begin
						state_q <= ST_DIV_HIGH;
					end
				end
				ST_DIV_HIGH: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rssi_noise_detector.sv =====
// Top level of the RSSI noise detector: front end, snapshot queue, back end.
// Depends on rnd_pkg, rnd_front, rnd_fifo and rnd_back.
//
// Usage:
//   Sample channel (sample_valid/sample_ready, op, rssi_sample): op = 0 opens a
//   new measurement window, op = 1 carries one RSSI reading in dBm; a reading
//   of zero is a timed-out read and leaves the window unchanged.
//   Result channel (result_valid/result_ready): one result per request, in
//   order, with both counts, both averages (-127 for an empty set) and the
//   high-noise flag.
//   Config port (wr_en, wr_index, wr_data): index 0 noise_threshold, index 1
//   min_high_count; write only while no request is in flight.
// Timing:
//   The front end applies a request in the cycle it is taken and queues the
//   updated sums and counts. The back end forms the two averages one after
//   the other on a shared divider that retires two quotient bits per cycle
//   and takes the next snapshot from the queue only once the last result is
//   registered; that divider sets the sustained rate.
// Reset clears the window and loads the config defaults (-80, 1). When the
// receiver stalls, hold the result; the queue keeps taking up to two more
// requests before sample_ready drops.
module rssi_noise_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [rnd_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rnd_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic                           op,
	input  logic signed [7:0]              rssi_sample,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [15:0]                    total_samples,
	output logic [15:0]                    high_samples,
	output logic signed [7:0]              mean_rssi,
	output logic signed [7:0]              mean_high_rssi,
	output logic                           high_noise
);

	// Snapshot path from front to back.
	logic           push, pop, fifo_full, fifo_empty;
	rnd_pkg::snap_t push_data, pop_data;

	// Take requests and keep the running window state.
	rnd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.op           (op),
		.rssi_sample  (rssi_sample),
		.fifo_full    (fifo_full),
		.push         (push),
		.push_data    (push_data)
	);

	// Decouple intake from the divider so each side stalls on its own.
	rnd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	// Divide, then present the result until taken.
	rnd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_empty     (fifo_empty),
		.fifo_data      (pop_data),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.total_samples  (total_samples),
		.high_samples   (high_samples),
		.mean_rssi      (mean_rssi),
		.mean_high_rssi (mean_high_rssi),
		.high_noise     (high_noise)
	);

endmodule

// ===== rtl/rnd_checker.sv =====
// Port-level checks for the RSSI noise detector, bound to its top level.
// Depends on rnd_pkg and rssi_noise_detector.
module rnd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input logic [15:0]       total_samples,
	input logic [15:0]       high_samples,
	input logic signed [7:0] mean_rssi,
	input logic signed [7:0] mean_high_rssi,
	input logic              high_noise
);

	localparam logic NARROW = rnd_pkg::COUNT_WIDTH <= 16;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(total_samples) && $stable(high_samples)
			&& $stable(mean_rssi) && $stable(mean_high_rssi) && $stable(high_noise))
		else $error("result payload changed while stalled");

	a_empty_high_mean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && NARROW && high_samples == 16'd0 |-> mean_high_rssi == rnd_pkg::EMPTY_MEAN)
		else $error("empty high set without empty mean");

	a_high_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && NARROW |-> high_samples <= total_samples)
		else $error("high count exceeds total count");

endmodule

bind rssi_noise_detector rnd_checker u_rnd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.total_samples  (total_samples),
	.high_samples   (high_samples),
	.mean_rssi      (mean_rssi),
	.mean_high_rssi (mean_high_rssi),
	.high_noise     (high_noise)
);
